// ===== src/lslm_pkg.sv =====
package lslm_pkg;

    localparam int unsigned LSLM_COUNT_WIDTH = 32;
    localparam int unsigned MAC_WIDTH        = 48;
    localparam int unsigned LEN_WIDTH        = 12;
    localparam int unsigned OUT_CNT_WIDTH    = 32;
    localparam int unsigned BCAST_LIM_WIDTH  = 17;
    localparam int unsigned LOOP_LIM_WIDTH   = 10;
    localparam int unsigned APB_ADDR_WIDTH   = 5;
    localparam int unsigned APB_DATA_WIDTH   = 64;

    localparam logic [MAC_WIDTH-1:0]       MAC_BROADCAST = '1;
    localparam logic [LEN_WIDTH-1:0]       MIN_FRAME_LEN = 12'd14;

    localparam logic [BCAST_LIM_WIDTH-1:0] BCAST_LIM_MIN   = 17'd100;
    localparam logic [BCAST_LIM_WIDTH-1:0] BCAST_LIM_MAX   = 17'd100000;
    localparam logic [BCAST_LIM_WIDTH-1:0] BCAST_LIM_RESET = 17'd1000;
    localparam logic [LOOP_LIM_WIDTH-1:0]  LOOP_LIM_MIN    = 10'd1;
    localparam logic [LOOP_LIM_WIDTH-1:0]  LOOP_LIM_MAX    = 10'd1000;
    localparam logic [LOOP_LIM_WIDTH-1:0]  LOOP_LIM_RESET  = 10'd1;

    typedef enum logic [1:0] {
        REG_OWN_MAC     = 2'd0,
        REG_BCAST_LIMIT = 2'd1,
        REG_LOOP_LIMIT  = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    localparam logic       REQ_FRAME = 1'b0;
    localparam logic       REQ_TICK  = 1'b1;

    localparam logic [2:0] NO_REPORT = 3'd4;

endpackage

// ===== src/lslm_req_if.sv =====
interface lslm_req_if
    import lslm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [MAC_WIDTH-1:0] dest_mac;
    logic [MAC_WIDTH-1:0] source_mac;
    logic [LEN_WIDTH-1:0] frame_length;

    modport source (
        output valid, req_type, dest_mac, source_mac, frame_length,
        input  ready
    );
    modport sink (
        input  valid, req_type, dest_mac, source_mac, frame_length,
        output ready
    );
endinterface

// ===== src/lslm_rpt_if.sv =====
interface lslm_rpt_if
    import lslm_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               health_state;
    logic [OUT_CNT_WIDTH-1:0] broadcast_count;
    logic [OUT_CNT_WIDTH-1:0] own_source_count;
    logic [OUT_CNT_WIDTH-1:0] frame_count;
    logic                     state_changed;

    modport source (
        output valid, health_state, broadcast_count, own_source_count, frame_count,
               state_changed,
        input  ready
    );
    modport sink (
        input  valid, health_state, broadcast_count, own_source_count, frame_count,
               state_changed,
        output ready
    );
endinterface

// ===== src/lan_storm_loop_monitor_unit.sv =====
// a tick goes through the input stage and then the report register before its report is valid
// throughput: one item per cycle; the input stalls only while a tick in the input
// stage waits for the report register to hand over an untaken report
// reset: synchronous, active low; counters cleared, own_mac 0, broadcast_limit 1000,
// loop_limit 1, no report yet so the first report is flagged as a change
module lan_storm_loop_monitor_unit
    import lslm_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = LSLM_COUNT_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lslm_req_if.sink                  i_req,
    lslm_rpt_if.source                o_rpt,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [MAC_WIDTH-1:0]       r_own_mac;
    logic [BCAST_LIM_WIDTH-1:0] r_bcast_limit;
    logic [LOOP_LIM_WIDTH-1:0]  r_loop_limit;

    logic r_s1_valid;
    logic r_s1_tick;
    logic r_s1_count;
    logic r_s1_own;
    logic r_s1_bcast;

    logic [COUNT_WIDTH-1:0] r_frames;
    logic [COUNT_WIDTH-1:0] r_bcasts;
    logic [COUNT_WIDTH-1:0] r_owns;
    logic [COUNT_WIDTH-1:0] n_frames;
    logic [COUNT_WIDTH-1:0] n_bcasts;
    logic [COUNT_WIDTH-1:0] n_owns;
    logic [2:0]             r_prev_state;

    logic                     r_out_valid;
    logic [1:0]               r_out_state;
    logic [OUT_CNT_WIDTH-1:0] r_out_bcast;
    logic [OUT_CNT_WIDTH-1:0] r_out_own;
    logic [OUT_CNT_WIDTH-1:0] r_out_frames;
    logic                     r_out_changed;

    logic       cfg_wr;
    t_reg_idx   cfg_idx;
    logic       out_free;
    logic       s1_adv;
    logic       s1_frame_adv;
    logic       s1_tick_adv;
    logic       in_xfer;
    logic [1:0] cur_state;
    logic [BCAST_LIM_WIDTH-1:0] wr_bcast;
    logic [LOOP_LIM_WIDTH-1:0]  wr_loop;

    function automatic logic [OUT_CNT_WIDTH-1:0] report_cnt(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] ext;
        ext = 64'(v);
        report_cnt = (ext > 64'({OUT_CNT_WIDTH{1'b1}})) ? '1 : ext[OUT_CNT_WIDTH-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign wr_bcast = pwdata[BCAST_LIM_WIDTH-1:0];
    assign wr_loop  = pwdata[LOOP_LIM_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac     <= '0;
            r_bcast_limit <= BCAST_LIM_RESET;
            r_loop_limit  <= LOOP_LIM_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OWN_MAC: begin
                    r_own_mac <= pwdata[MAC_WIDTH-1:0];
                end
                REG_BCAST_LIMIT: begin
                    if (wr_bcast < BCAST_LIM_MIN) begin
                        r_bcast_limit <= BCAST_LIM_MIN;
                    end else if (wr_bcast > BCAST_LIM_MAX) begin
                        r_bcast_limit <= BCAST_LIM_MAX;
                    end else begin
                        r_bcast_limit <= wr_bcast;
                    end
                end
                REG_LOOP_LIMIT: begin
                    if (wr_loop < LOOP_LIM_MIN) begin
                        r_loop_limit <= LOOP_LIM_MIN;
                    end else if (wr_loop > LOOP_LIM_MAX) begin
                        r_loop_limit <= LOOP_LIM_MAX;
                    end else begin
                        r_loop_limit <= wr_loop;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OWN_MAC:     prdata = APB_DATA_WIDTH'(r_own_mac);
            REG_BCAST_LIMIT: prdata = APB_DATA_WIDTH'(r_bcast_limit);
            REG_LOOP_LIMIT:  prdata = APB_DATA_WIDTH'(r_loop_limit);
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign out_free     = !r_out_valid || o_rpt.ready;
    assign s1_adv       = r_s1_valid && (!r_s1_tick || out_free);
    assign s1_frame_adv = r_s1_valid && !r_s1_tick;
    assign s1_tick_adv  = r_s1_valid && r_s1_tick && out_free;
    assign i_req.ready  = !r_s1_valid || s1_adv;
    assign in_xfer      = i_req.valid && i_req.ready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_tick  <= (i_req.req_type == REQ_TICK);
            r_s1_count <= (i_req.frame_length >= MIN_FRAME_LEN);
            r_s1_own   <= (i_req.source_mac == r_own_mac);
            r_s1_bcast <= (i_req.dest_mac == MAC_BROADCAST);
        end
    end

    // window counters
    assign cur_state = {(r_bcasts >= COUNT_WIDTH'(r_bcast_limit)),
                        (r_owns >= COUNT_WIDTH'(r_loop_limit))};

    always_comb begin
        n_frames = r_frames;
        n_bcasts = r_bcasts;
        n_owns   = r_owns;
        if (s1_tick_adv) begin
            n_frames = '0;
            n_bcasts = '0;
            n_owns   = '0;
        end else if (s1_frame_adv && r_s1_count) begin
            n_frames = sat_inc(r_frames);
            if (r_s1_bcast) begin
                n_bcasts = sat_inc(r_bcasts);
            end
            if (r_s1_own) begin
                n_owns = sat_inc(r_owns);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames     <= '0;
            r_bcasts     <= '0;
            r_owns       <= '0;
            r_prev_state <= NO_REPORT;
        end else begin
            r_frames <= n_frames;
            r_bcasts <= n_bcasts;
            r_owns   <= n_owns;
            if (s1_tick_adv) begin
                r_prev_state <= {1'b0, cur_state};
            end
        end
    end

    // report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_tick_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rpt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_tick_adv) begin
            r_out_state   <= cur_state;
            r_out_bcast   <= report_cnt(r_bcasts);
            r_out_own     <= report_cnt(r_owns);
            r_out_frames  <= report_cnt(r_frames);
            r_out_changed <= ({1'b0, cur_state} != r_prev_state);
        end
    end

    assign o_rpt.valid            = r_out_valid;
    assign o_rpt.health_state     = r_out_state;
    assign o_rpt.broadcast_count  = r_out_bcast;
    assign o_rpt.own_source_count = r_out_own;
    assign o_rpt.frame_count      = r_out_frames;
    assign o_rpt.state_changed    = r_out_changed;

`ifndef ASSERT_OFF
    a_tick_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_tick_adv |=> r_out_valid)
        else $error("tick did not load a report");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_tick_adv |=> (r_frames == '0 && r_bcasts == '0 && r_owns == '0))
        else $error("counters not cleared after window end");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames >= r_bcasts) && (r_frames >= r_owns))
        else $error("frame count below a sub count");

    a_prev_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_prev_state != NO_REPORT))
        else $error("report shown without recorded state");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_s1_valid && r_s1_tick && r_out_valid))
        else $error("input stalled without a blocked tick");
`endif

endmodule
